FILE: design/refcounted_name_id_table_assert.svh
// Assertion macros for the name/id table RTL.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef REFCOUNTED_NAME_ID_TABLE_ASSERT_SVH
`define REFCOUNTED_NAME_ID_TABLE_ASSERT_SVH

// Same-cycle implication, reset masked.
`define RNIT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rnit assertion failed");

// Next-cycle implication, reset masked.
`define RNIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rnit assertion failed");

`endif

FILE: design/rnit_pkg.sv
// Package for the name/id table: sizes, codes, command/status structs.
// Depends on nothing.
package rnit_pkg;
    localparam int ENTRIES    = 255;
    localparam int NAME_BYTES = 32;
    localparam int COUNT_BITS = 16;
    localparam int NWORDS     = 4;
    localparam int WORD_W     = 64;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NAME_W     = NWORDS * WORD_W;
    localparam int ENT_W      = NAME_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_INTERN = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REF    = 2'd2,
        ACT_UNREF  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic scan;
        logic read;
        logic eval;
    } t_cmd;

    typedef struct packed {
        logic fast;
        logic intern;
        logic scan_last;
    } t_stat;

    // Zero the first zero byte, all bytes after it and all beyond NAME_BYTES.
    function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
        logic              keep;
        logic [NAME_W-1:0] res;
        keep = 1'b1;
        res  = '0;
        for (int i = 0; i < NWORDS * 8; i++) begin
            if (i >= NAME_BYTES || raw[8*i +: 8] == 8'd0) keep = 1'b0;
            if (keep) res[8*i +: 8] = raw[8*i +: 8];
        end
        return res;
    endfunction
endpackage

FILE: design/rnit_in_if.sv
// Request channel of the name/id table: valid/ready plus request fields.
// Depends on nothing.
interface rnit_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  request_id;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [63:0] name_word3;

    modport source(output valid, action, request_id, name_word0, name_word1,
                   name_word2, name_word3, input ready);
    modport sink(input valid, action, request_id, name_word0, name_word1,
                 name_word2, name_word3, output ready);
endinterface

FILE: design/rnit_out_if.sv
// Result channel of the name/id table: valid/ready plus result fields.
// Depends on nothing.
interface rnit_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  result_id;
    logic [1:0]  status;
    logic [63:0] out_name_word0;
    logic [63:0] out_name_word1;
    logic [63:0] out_name_word2;
    logic [63:0] out_name_word3;

    modport source(output valid, result_id, status, out_name_word0, out_name_word1,
                   out_name_word2, out_name_word3, input ready);
    modport sink(input valid, result_id, status, out_name_word0, out_name_word1,
                 out_name_word2, out_name_word3, output ready);
endinterface

FILE: design/refcounted_name_id_table.sv
// Reference-counted name/id table, top level: joins controller and datapath.
// Depends on rnit_pkg, rnit_in_if, rnit_out_if, rnit_ctrl, rnit_dp.
//
// The block takes one request item at a time and returns exactly one result
// item per request. An intern of a non-empty name walks every entry through
// the single read port of the entry RAM, one entry per cycle, to find the
// first live match and the lowest free id. Lookup, ref and unref of a live
// id read one entry; an empty name or an unknown id answers without a read.
// The next request is taken in the cycle after the result item leaves.
// Live bits sit in flip-flops and clear at reset; counts and names are in
// RAM and are only read for live entries, so there is no clearing pass
// after reset. Id 0 is the empty label, a full table answers id 0.
module refcounted_name_id_table (
    input logic       i_clk,
    input logic       i_rst_n,
    rnit_in_if.sink   i_in,
    rnit_out_if.source o_out
);
    import rnit_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequence each request item.
    rnit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold table state and compute results.
    rnit_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_in.action),
        .i_request_id    (i_in.request_id),
        .i_name_word0    (i_in.name_word0),
        .i_name_word1    (i_in.name_word1),
        .i_name_word2    (i_in.name_word2),
        .i_name_word3    (i_in.name_word3),
        .o_result_id     (o_out.result_id),
        .o_status        (o_out.status),
        .o_out_name_word0(o_out.out_name_word0),
        .o_out_name_word1(o_out.out_name_word1),
        .o_out_name_word2(o_out.out_name_word2),
        .o_out_name_word3(o_out.out_name_word3)
    );
endmodule

FILE: design/rnit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rnit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/rnit_ctrl.sv
// Controller FSM of the name/id table: sequences accept, scan, read,
// evaluate and result hand-off. Depends on rnit_pkg and the assert header.
`include "refcounted_name_id_table_assert.svh"
module rnit_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rnit_pkg::t_stat i_stat,
    output rnit_pkg::t_cmd  o_cmd
);
    import rnit_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_READ  = 6'b001000,
        S_EVAL  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = o_in_ready && i_in_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.load = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.fast) n_state = S_OUT;
                    else if (i_stat.intern) n_state = S_SCAN;
                    else n_state = S_READ;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_EVAL;
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    `RNIT_ASSERT_NEXT(a_eval_to_out, r_state == S_EVAL, r_state == S_OUT)
    `RNIT_ASSERT_NOW(a_no_overlap, o_out_valid, !o_in_ready)
    `RNIT_ASSERT_NEXT(a_fast_done, accept && i_stat.fast, r_state == S_OUT)
endmodule

FILE: design/rnit_dp.sv
// Datapath of the name/id table: request registers, live bits, entry RAM,
// scan compare and update logic. Depends on rnit_pkg and rnit_ram.
module rnit_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rnit_pkg::t_cmd  i_cmd,
    output rnit_pkg::t_stat o_stat,
    input  logic [1:0]      i_action,
    input  logic [7:0]      i_request_id,
    input  logic [63:0]     i_name_word0,
    input  logic [63:0]     i_name_word1,
    input  logic [63:0]     i_name_word2,
    input  logic [63:0]     i_name_word3,
    output logic [7:0]      o_result_id,
    output logic [1:0]      o_status,
    output logic [63:0]     o_out_name_word0,
    output logic [63:0]     o_out_name_word1,
    output logic [63:0]     o_out_name_word2,
    output logic [63:0]     o_out_name_word3
);
    import rnit_pkg::*;

    t_action               r_action;
    logic [7:0]            r_id;
    logic [IDX_W-1:0]      r_idx;
    logic [NAME_W-1:0]     r_name;
    logic [IDX_W-1:0]      r_cnt;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_pidx;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hidx;
    logic [COUNT_BITS-1:0] r_hcnt;
    logic                  r_free_ok;
    logic [IDX_W-1:0]      r_fidx;
    logic                  r_live [ENTRIES];
    logic [7:0]            r_rid;
    t_status               r_status;
    logic [NAME_W-1:0]     r_oname;

    logic [NAME_W-1:0]     raw;
    logic [IDX_W-1:0]      id_idx;
    logic                  id_ok;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENT_W-1:0]      rd_data;
    logic [NAME_W-1:0]     rd_name;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ENT_W-1:0]      wdata;
    logic                  live_set;
    logic                  live_clr;
    logic [7:0]            n_rid;
    t_status               n_status;
    logic [NAME_W-1:0]     n_oname;
    logic [COUNT_BITS-1:0] dec_cnt;

    assign raw    = {i_name_word3, i_name_word2, i_name_word1, i_name_word0};
    assign id_idx = IDX_W'(32'(i_request_id) - 1);
    assign id_ok  = (i_request_id != 8'd0) && (32'(i_request_id) <= ENTRIES)
                    && r_live[id_idx];

    assign o_stat.fast      = (t_action'(i_action) == ACT_INTERN) ? (raw[7:0] == 8'd0)
                                                                  : !id_ok;
    assign o_stat.intern    = (t_action'(i_action) == ACT_INTERN);
    assign o_stat.scan_last = (r_cnt == IDX_W'(ENTRIES - 1));

    assign rd_addr = i_cmd.scan ? r_cnt : r_idx;
    assign rd_name = rd_data[ENT_W-1:COUNT_BITS];
    assign rd_cnt  = rd_data[COUNT_BITS-1:0];
    assign dec_cnt = (rd_cnt != '0) ? rd_cnt - 1'b1 : rd_cnt;

    rnit_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // Outcome of one request, applied in the evaluate cycle.
    always_comb begin
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = {rd_name, rd_cnt};
        live_set = 1'b0;
        live_clr = 1'b0;
        n_rid    = 8'd0;
        n_status = ST_EMPTY;
        n_oname  = '0;
        case (r_action)
            ACT_INTERN: begin
                if (r_hit) begin
                    if (r_hcnt == COUNT_MAX) begin
                        n_status = ST_SAT;
                    end else begin
                        we       = 1'b1;
                        waddr    = r_hidx;
                        wdata    = {r_name, r_hcnt + 1'b1};
                        n_rid    = 8'(32'(r_hidx) + 1);
                        n_status = ST_OK;
                    end
                end else if (!r_free_ok) begin
                    n_status = ST_FULL;
                end else begin
                    we       = 1'b1;
                    waddr    = r_fidx;
                    wdata    = {r_name, COUNT_BITS'(1)};
                    live_set = 1'b1;
                    n_rid    = 8'(32'(r_fidx) + 1);
                    n_status = ST_OK;
                end
            end
            ACT_LOOKUP: begin
                n_oname  = rd_name;
                n_status = ST_OK;
            end
            ACT_REF: begin
                if (rd_cnt == COUNT_MAX) begin
                    n_status = ST_SAT;
                end else begin
                    we       = 1'b1;
                    wdata    = {rd_name, rd_cnt + 1'b1};
                    n_rid    = r_id;
                    n_status = ST_OK;
                end
            end
            ACT_UNREF: begin
                we       = 1'b1;
                wdata    = {rd_name, dec_cnt};
                live_clr = (dec_cnt == '0);
                n_status = ST_OK;
            end
            default: n_status = ST_EMPTY;
        endcase
        if (!i_cmd.eval) begin
            we       = 1'b0;
            live_set = 1'b0;
            live_clr = 1'b0;
        end
    end

    // Control state: scan pointer, compare pipeline, hit/free flags, live bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            for (int k = 0; k < ENTRIES; k++) r_live[k] <= 1'b0;
        end else begin
            r_pend <= i_cmd.scan;
            if (i_cmd.load) begin
                r_cnt     <= '0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end else begin
                if (i_cmd.scan) r_cnt <= r_cnt + 1'b1;
                if (r_pend) begin
                    if (r_live[r_pidx]) begin
                        if (!r_hit && rd_name == r_name) r_hit <= 1'b1;
                    end else if (!r_free_ok) begin
                        r_free_ok <= 1'b1;
                    end
                end
            end
            if (live_set) r_live[waddr] <= 1'b1;
            if (live_clr) r_live[waddr] <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt;
        if (r_pend && r_live[r_pidx] && !r_hit && rd_name == r_name) begin
            r_hidx <= r_pidx;
            r_hcnt <= rd_cnt;
        end
        if (r_pend && !r_live[r_pidx] && !r_free_ok) r_fidx <= r_pidx;
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_id     <= i_request_id;
            r_idx    <= id_idx;
            r_name   <= normalize(raw);
            r_rid    <= 8'd0;
            r_status <= ST_EMPTY;
            r_oname  <= '0;
        end else if (i_cmd.eval) begin
            r_rid    <= n_rid;
            r_status <= n_status;
            r_oname  <= n_oname;
        end
    end

    assign o_result_id      = r_rid;
    assign o_status         = r_status;
    assign o_out_name_word0 = r_oname[0*WORD_W +: WORD_W];
    assign o_out_name_word1 = r_oname[1*WORD_W +: WORD_W];
    assign o_out_name_word2 = r_oname[2*WORD_W +: WORD_W];
    assign o_out_name_word3 = r_oname[3*WORD_W +: WORD_W];
endmodule

FILE: tb/sv/rnit_checker.sv
// Checker for the name/id table: watches both channels, predicts each result
// item from its own copy of the table state, and compares. Depends on rnit_pkg.
module rnit_checker
    import rnit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rnit_in_if.sink     i_in_mon,
    rnit_out_if.sink    i_out_mon,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [7:0]        rid;
        t_status           st;
        logic [NAME_W-1:0] nm;
    } t_answer;

    logic                  live_tbl [ENTRIES];
    logic [COUNT_BITS-1:0] count_tbl [ENTRIES];
    logic [NAME_W-1:0]     name_tbl [ENTRIES];
    t_answer               answers_due [$];
    int                    fails;

    assign o_fail_count = fails;
    assign o_pending    = answers_due.size();

    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic              ended;
        logic [NAME_W-1:0] res;
        ended = 1'b0;
        res   = '0;
        for (int b = 0; b < NWORDS * 8; b++) begin
            if (b >= NAME_BYTES || raw[8*b +: 8] == 8'd0) ended = 1'b1;
            if (!ended) res[8*b +: 8] = raw[8*b +: 8];
        end
        return res;
    endfunction

    function automatic int live_slot(input logic [7:0] id);
        if (id == 0 || id > ENTRIES) return -1;
        if (!live_tbl[id-1]) return -1;
        return id - 1;
    endfunction

    // Apply one request to the shadow table and return its answer.
    function automatic t_answer apply_request(input t_action act, input logic [7:0] id,
                                              input logic [NAME_W-1:0] raw);
        t_answer           a;
        logic [NAME_W-1:0] w;
        int                hit;
        int                free_e;
        a.rid = '0;
        a.st  = ST_EMPTY;
        a.nm  = '0;
        case (act)
            ACT_INTERN: begin
                w      = trim_name(raw);
                hit    = -1;
                free_e = -1;
                if (w[63:0] != 0) begin
                    for (int k = 0; k < ENTRIES; k++) begin
                        if (live_tbl[k]) begin
                            if (hit < 0 && name_tbl[k] == w) hit = k;
                        end else if (free_e < 0) begin
                            free_e = k;
                        end
                    end
                    if (hit >= 0) begin
                        if (count_tbl[hit] == COUNT_MAX) begin
                            a.st = ST_SAT;
                        end else begin
                            count_tbl[hit]++;
                            a.rid = 8'(hit + 1);
                            a.st  = ST_OK;
                        end
                    end else if (free_e < 0) begin
                        a.st = ST_FULL;
                    end else begin
                        live_tbl[free_e]  = 1'b1;
                        count_tbl[free_e] = 1;
                        name_tbl[free_e]  = w;
                        a.rid = 8'(free_e + 1);
                        a.st  = ST_OK;
                    end
                end
            end
            ACT_LOOKUP: begin
                hit = live_slot(id);
                if (hit >= 0) begin
                    a.nm = name_tbl[hit];
                    a.st = ST_OK;
                end
            end
            ACT_REF: begin
                hit = live_slot(id);
                if (hit >= 0) begin
                    if (count_tbl[hit] == COUNT_MAX) begin
                        a.st = ST_SAT;
                    end else begin
                        count_tbl[hit]++;
                        a.rid = id;
                        a.st  = ST_OK;
                    end
                end
            end
            default: begin
                hit = live_slot(id);
                if (hit >= 0) begin
                    if (count_tbl[hit] > 0) count_tbl[hit]--;
                    if (count_tbl[hit] == 0) live_tbl[hit] = 1'b0;
                    a.st = ST_OK;
                end
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                live_tbl[k]  = 1'b0;
                count_tbl[k] = '0;
                name_tbl[k]  = '0;
            end
            answers_due.delete();
            fails = 0;
        end else begin
            // Consume the result first: a request accepted now answers later.
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.rid = i_out_mon.result_id;
                got.st  = t_status'(i_out_mon.status);
                got.nm  = {i_out_mon.out_name_word3, i_out_mon.out_name_word2,
                           i_out_mon.out_name_word1, i_out_mon.out_name_word0};
                if (answers_due.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = answers_due.pop_front();
                    if (got.rid !== want.rid)
                        report_mismatch($sformatf("result_id %0d, want %0d",
                                                  got.rid, want.rid));
                    if (got.st !== want.st)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.st, want.st));
                    if (got.nm !== want.nm)
                        report_mismatch($sformatf("name %h, want %h", got.nm, want.nm));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                answers_due.push_back(apply_request(t_action'(i_in_mon.action),
                    i_in_mon.request_id,
                    {i_in_mon.name_word3, i_in_mon.name_word2,
                     i_in_mon.name_word1, i_in_mon.name_word0}));
        end
    end
endmodule

FILE: tb/sv/tb_refcounted_name_id_table.sv
// Testbench top for the name/id table: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on rnit_pkg, both channel
// interfaces, rnit_checker and the block itself.
module tb_refcounted_name_id_table;
    import rnit_pkg::*;

    // Idle cycles the watchdog tolerates: an intern scan plus the longest
    // random gap on either side, taken many times over.
    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;
    logic [NAME_W-1:0] name_pool [16];

    rnit_in_if  req_ch ();
    rnit_out_if res_ch ();

    refcounted_name_id_table dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch.sink),
        .o_out  (res_ch.source)
    );

    rnit_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (req_ch.sink),
        .i_out_mon   (res_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Back-pressure the result channel at the current idle rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Random name of 1..32 nonzero bytes, sometimes with junk bytes after its end.
    function automatic logic [NAME_W-1:0] random_name();
        logic [NAME_W-1:0] n;
        int                len;
        n   = '0;
        len = $urandom_range(1, 32);
        for (int b = 0; b < 32; b++) begin
            if (b < len) n[8*b +: 8] = 8'($urandom_range(1, 255));
            else if ($urandom_range(3) == 0) n[8*b +: 8] = 8'($urandom);
        end
        return n;
    endfunction

    // Present one request and hold it until accepted; valid stays high after it
    // for the next item or until drop_valid.
    task automatic send_request(input t_action act, input logic [7:0] id,
                                input logic [NAME_W-1:0] nm);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.request_id <= id;
        {req_ch.name_word3, req_ch.name_word2, req_ch.name_word1, req_ch.name_word0} <= nm;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drop_valid();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
    endtask

    // Weighted random request: mostly hits on ids and names in use.
    task automatic random_request();
        int          pick;
        logic [7:0]  id;
        pick = $urandom_range(99);
        id   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
        if (pick < 35)
            send_request(ACT_INTERN, 8'($urandom), name_pool[$urandom_range(15)]);
        else if (pick < 45)
            send_request(ACT_INTERN, 8'($urandom), random_name());
        else if (pick < 65)
            send_request(ACT_LOOKUP, id, {4{64'($urandom) << 32 | 64'($urandom)}});
        else if (pick < 80)
            send_request(ACT_REF, id, '0);
        else
            send_request(ACT_UNREF, id, '0);
    endtask

    initial begin
        logic [NAME_W-1:0] full_name;
        i_rst_n           = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_INTERN;
        req_ch.request_id = '0;
        req_ch.name_word0 = '0;
        req_ch.name_word1 = '0;
        req_ch.name_word2 = '0;
        req_ch.name_word3 = '0;
        for (int p = 0; p < 16; p++) name_pool[p] = random_name();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: id zero, empty name, full-width name, junk after the
        // terminator, every action on live and unknown ids.
        full_name = '1;
        send_request(ACT_LOOKUP, 8'd0, '0);
        send_request(ACT_REF, 8'd0, '0);
        send_request(ACT_UNREF, 8'd0, '0);
        send_request(ACT_INTERN, 8'd0, {{31{8'hff}}, 8'h00});
        send_request(ACT_INTERN, 8'hff, full_name);
        send_request(ACT_INTERN, 8'd0, {{30{8'h5a}}, 8'h00, 8'h41});
        send_request(ACT_INTERN, 8'd0, {{31{8'h00}}, 8'h41});
        send_request(ACT_LOOKUP, 8'd1, '0);
        send_request(ACT_LOOKUP, 8'd2, full_name);
        send_request(ACT_LOOKUP, 8'd255, '0);
        send_request(ACT_REF, 8'd2, '0);
        send_request(ACT_REF, 8'd200, '0);
        send_request(ACT_UNREF, 8'd2, '0);
        send_request(ACT_UNREF, 8'd2, '0);
        send_request(ACT_LOOKUP, 8'd2, '0);
        send_request(ACT_UNREF, 8'd1, '0);
        send_request(ACT_INTERN, 8'd0, {{31{8'h00}}, 8'h42});
        send_request(ACT_LOOKUP, 8'd1, '0);
        drop_valid();

        // Fill the table with distinct names, hit full, then free them all.
        for (int e = 0; e < ENTRIES; e++)
            send_request(ACT_INTERN, 8'd0, {{30{8'h00}}, 8'(e + 1), 8'h7e});
        send_request(ACT_INTERN, 8'd0, full_name);
        send_request(ACT_LOOKUP, 8'd255, '0);
        for (int e = 1; e <= ENTRIES; e++) send_request(ACT_UNREF, 8'(e), '0);
        drop_valid();

        // Random phases: receiver slow, then sender slow, then no idling.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 60 : 0;
            recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 31 : 0;
            for (int n = 0; n < 60; n++) random_request();
            drop_valid();
        end

        drain();
        recv_idle_pct = 0;
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
